// ----- rtl/rfd_pkg.sv -----
package rfd_pkg;

  localparam int CAPACITY = 16;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int FILL_W   = 5;

  // command codes
  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_PEEK = 2'd2;
  localparam logic [1:0] CMD_DEL  = 2'd3;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] data_in;
  } cmd_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] data_out;
    logic                     is_empty;
    logic                     is_full;
    logic [FILL_W-1:0]        fill_count;
  } rsp_t;

endpackage

// ----- rtl/rfd_ram.sv -----
module rfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ring_fifo_with_delete.sv -----
// ring buffer fifo of signed 32-bit values with delete by value
//
// command channel: cmd_valid / cmd_stall carry one item {command, data_in};
// commands are enqueue, dequeue, peek and delete of the first matching value
// response channel: rsp_valid / rsp_stall carry one item per command with
// ok, data_out and the empty / full / fill status after the command
//
// one command is worked on at a time; cmd_stall is high while it runs
// enqueue, a full enqueue and any command on an empty queue go straight to
// the response; dequeue and peek first take one registered ram read; a
// delete searches from the head, drops a head match directly, shifts the
// later entries a slot toward the head for a match elsewhere and responds
// after the search if nothing matches; the search and then the shift walk
// one entry per cycle through the single slot ram port
//
// the finished response sits in an output register; a stalled receiver holds
// it there, and a new command may be accepted meanwhile, but the next
// response waits until the register is taken
// reset clears pointers, count and the response valid; slot contents are not
// cleared, since only entries that were written are ever read
module ring_fifo_with_delete (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  rfd_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output rfd_pkg::rsp_t rsp
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_SHIFT  = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  // circular pointer step, works for any capacity
  function automatic logic [rfd_pkg::PTR_W-1:0] ptr_inc(
    input logic [rfd_pkg::PTR_W-1:0] p
  );
    if (p == rfd_pkg::PTR_W'(rfd_pkg::CAPACITY - 1)) begin
      return '0;
    end
    return p + rfd_pkg::PTR_W'(1);
  endfunction

  function automatic logic [rfd_pkg::PTR_W-1:0] ptr_dec(
    input logic [rfd_pkg::PTR_W-1:0] p
  );
    if (p == '0) begin
      return rfd_pkg::PTR_W'(rfd_pkg::CAPACITY - 1);
    end
    return p - rfd_pkg::PTR_W'(1);
  endfunction

  // control state
  state_t                    state, state_next;
  logic [rfd_pkg::PTR_W-1:0] head, head_next;
  logic [rfd_pkg::PTR_W-1:0] tail, tail_next;
  logic [rfd_pkg::CNT_W-1:0] count, count_next;
  logic                      rsp_valid_next;

  // working registers of the sequencer
  logic [1:0]                       op, op_next;
  logic signed [rfd_pkg::DATA_W-1:0] key, key_next;
  logic [rfd_pkg::CNT_W-1:0]        k, k_next;      // search offset, then shift source offset
  logic [rfd_pkg::PTR_W-1:0]        p, p_next;      // slot address of offset k while searching
  logic [rfd_pkg::PTR_W-1:0]        wptr, wptr_next; // shift destination slot
  logic [rfd_pkg::PTR_W-1:0]        sptr, sptr_next; // shift source slot, its data in ram_rdata
  logic                             res_ok, res_ok_next;
  logic signed [rfd_pkg::DATA_W-1:0] res_data, res_data_next;
  rfd_pkg::rsp_t                    rsp_next;
  logic                             rsp_load;

  // slot ram port
  logic                      ram_we;
  logic [rfd_pkg::PTR_W-1:0] ram_waddr;
  logic [rfd_pkg::DATA_W-1:0] ram_wdata;
  logic [rfd_pkg::PTR_W-1:0] ram_raddr;
  logic [rfd_pkg::DATA_W-1:0] ram_rdata;

  rfd_ram #(
    .WIDTH (rfd_pkg::DATA_W),
    .DEPTH (rfd_pkg::CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // only idle takes a new command
  assign cmd_stall = (state != ST_IDLE);

  // response register is free when empty or being taken this cycle
  assign rsp_load = (state == ST_RESP) && (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    op_next       = op;
    key_next      = key;
    k_next        = k;
    p_next        = p;
    wptr_next     = wptr;
    sptr_next     = sptr;
    res_ok_next   = res_ok;
    res_data_next = res_data;
    ram_we        = 1'b0;
    ram_waddr     = tail;
    ram_wdata     = cmd.data_in;
    ram_raddr     = head;

    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          op_next       = cmd.command;
          key_next      = cmd.data_in;
          res_ok_next   = 1'b0;
          res_data_next = '0;
          state_next    = ST_RESP;
          case (cmd.command)
            rfd_pkg::CMD_ENQ: begin
              if (count < rfd_pkg::CNT_W'(rfd_pkg::CAPACITY)) begin
                ram_we      = 1'b1;
                ram_waddr   = tail;
                ram_wdata   = cmd.data_in;
                tail_next   = ptr_inc(tail);
                count_next  = count + rfd_pkg::CNT_W'(1);
                res_ok_next = 1'b1;
              end
            end
            rfd_pkg::CMD_DEQ, rfd_pkg::CMD_PEEK: begin
              // head read issued now, data back next cycle
              if (count != '0) begin
                ram_raddr  = head;
                state_next = ST_READ;
              end
            end
            default: begin
              // delete: start the search at the head
              if (count != '0) begin
                ram_raddr  = head;
                p_next     = head;
                k_next     = '0;
                state_next = ST_SEARCH;
              end
            end
          endcase
        end
      end

      ST_READ: begin
        res_ok_next   = 1'b1;
        res_data_next = ram_rdata;
        if (op == rfd_pkg::CMD_DEQ) begin
          head_next  = ptr_inc(head);
          count_next = count - rfd_pkg::CNT_W'(1);
        end
        state_next = ST_RESP;
      end

      ST_SEARCH: begin
        // ram_rdata holds the entry at offset k; fetch the next one ahead
        ram_raddr = ptr_inc(p);
        if (ram_rdata == key) begin
          if (k == '0) begin
            // match at the head: just drop it
            head_next   = ptr_inc(head);
            count_next  = count - rfd_pkg::CNT_W'(1);
            res_ok_next = 1'b1;
            state_next  = ST_RESP;
          end else begin
            // entry after the match is already on its way out of the ram
            wptr_next  = p;
            sptr_next  = ptr_inc(p);
            k_next     = k + rfd_pkg::CNT_W'(1);
            state_next = ST_SHIFT;
          end
        end else if (k + rfd_pkg::CNT_W'(1) == count) begin
          state_next = ST_RESP;
        end else begin
          p_next = ptr_inc(p);
          k_next = k + rfd_pkg::CNT_W'(1);
        end
      end

      ST_SHIFT: begin
        if (k < count) begin
          // move one later entry a slot toward the head
          ram_we    = 1'b1;
          ram_waddr = wptr;
          ram_wdata = ram_rdata;
          ram_raddr = ptr_inc(sptr);
          wptr_next = sptr;
          sptr_next = ptr_inc(sptr);
          k_next    = k + rfd_pkg::CNT_W'(1);
        end else begin
          tail_next   = ptr_dec(tail);
          count_next  = count - rfd_pkg::CNT_W'(1);
          res_ok_next = 1'b1;
          state_next  = ST_RESP;
        end
      end

      ST_RESP: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // status reflects the fill after the command
  always_comb begin
    rsp_next.ok         = res_ok;
    rsp_next.data_out   = res_data;
    rsp_next.is_empty   = (count == '0);
    rsp_next.is_full    = (count == rfd_pkg::CNT_W'(rfd_pkg::CAPACITY));
    rsp_next.fill_count = rfd_pkg::FILL_W'(count);
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    op       <= op_next;
    key      <= key_next;
    k        <= k_next;
    p        <= p_next;
    wptr     <= wptr_next;
    sptr     <= sptr_next;
    res_ok   <= res_ok_next;
    res_data <= res_data_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule
